>>> rtl/glyph_and_kern_table_search_defines.svh
// assertion macros for the glyph and kern table search top level rtl
// no dependencies; the including module must have aclk and aresetn in scope
`ifndef GLYPH_AND_KERN_TABLE_SEARCH_DEFINES_SVH
`define GLYPH_AND_KERN_TABLE_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define GKS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gks assertion failed");
`define GKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gks assertion failed");
`else
`define GKS_ASSERT_SAME(label, ante, cons)
`define GKS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/gks_pkg.sv
// constants, codes and field layouts for the glyph and kern table search
// no dependencies
package gks_pkg;

    localparam int GLYPH_DEPTH_DEF = 1024;
    localparam int KERN_DEPTH_DEF  = 1024;

    // field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 10;
    localparam int CP_W    = 21;
    localparam int M16_W   = 16;
    localparam int BMS_W   = 32;
    localparam int IDX_W   = 10;
    localparam int KKEY_W  = 2 * IDX_W;
    localparam int USED_W  = 11;
    localparam int POS_W   = 10;

    // stream widths
    localparam int S_TDATA_W = 184;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 144;
    localparam int M_TUSER_W = 1;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_USED = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERN_USED  = 4'd1;

    // operation codes
    localparam logic [OP_W-1:0] OP_WRITE_GLYPH = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_KERN  = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND_GLYPH  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND_KERN   = 2'd3;

    // glyph memory entry: key, bearing x, bearing y, width, height, advance, bitmap start
    localparam int GENT_W = CP_W + 5 * M16_W + BMS_W;
    // kern memory entry: key, value
    localparam int KENT_W = KKEY_W + M16_W;

endpackage

>>> rtl/glyph_and_kern_table_search.sv
// top level of the glyph and kern table search: stream ports, config registers, bisection sequencer
// depends on gks_pkg, gks_ram and glyph_and_kern_table_search_defines.svh
//
// Holds a glyph table (codepoint key plus metrics) and a kern table (key built
// from a left and a right glyph index plus an adjustment), each in its own
// memory, and answers lookups by binary search over the first entries_used
// entries, which must be sorted ascending by key. Write items (op 0 and 1)
// store one entry at the given slot on acceptance and give no result;
// slots at or beyond the table depth are dropped. Find items (op 2 and 3) give
// exactly one result item. Entries have no reset value: only search tables
// whose used part has been written. A find over n used entries makes at most
// ceil(log2(n + 1)) bisection steps, each a read of the midpoint from the
// memory's registered read port (issue state) and then the shared key compare
// and bound update (compare state). A hit goes on to the done state; a miss
// first passes the empty-range check in the issue state. The done state waits
// for a free output register. The input side is held off (s_tready low) from
// acceptance of a find item until its result is loaded into the output
// register and is ready again the cycle after, so find items never overlap;
// a result waiting on m_tready does not block the next item being accepted.
// Config writes are taken every cycle and should only be issued while the
// block is idle.
`include "glyph_and_kern_table_search_defines.svh"

module glyph_and_kern_table_search #(
    parameter int GLYPH_DEPTH = gks_pkg::GLYPH_DEPTH_DEF,
    parameter int KERN_DEPTH  = gks_pkg::KERN_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gks_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gks_pkg::USED_W-1:0]       cfg_data,

    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // slot, codepoint, bearing_x_in, bearing_y_in, width_in, height_in, advance_in,
    // bitmap_start_in, left_index, right_index, kern_value_in, zero pad
    input  logic [gks_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic [gks_pkg::S_TUSER_W-1:0]    s_tuser,

    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // glyph_position, bearing_x_out, bearing_y_out, width_out, height_out, advance_out,
    // bitmap_start_out, kern_value_out, zero pad
    output logic [gks_pkg::M_TDATA_W-1:0]    m_tdata,
    // found
    output logic [gks_pkg::M_TUSER_W-1:0]    m_tuser
);

    import gks_pkg::*;

    localparam int GAW   = $clog2(GLYPH_DEPTH);
    localparam int KAW   = $clog2(KERN_DEPTH);
    localparam int MAXD  = (GLYPH_DEPTH > KERN_DEPTH) ? GLYPH_DEPTH : KERN_DEPTH;
    // bounds run from 0 to the used count, which never exceeds the depth
    localparam int CW    = $clog2(MAXD + 1);
    localparam int PAD_W = M_TDATA_W - (POS_W + 6 * M16_W + BMS_W);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // input field unpacking
    logic [OP_W-1:0]   in_op;
    logic [SLOT_W-1:0] in_slot;
    logic [CP_W-1:0]   in_cp;
    logic [M16_W-1:0]  in_bx, in_by, in_w, in_h, in_adv, in_kern;
    logic [BMS_W-1:0]  in_bms;
    logic [IDX_W-1:0]  in_left, in_right;

    assign in_op    = s_tuser;
    assign in_slot  = s_tdata[9:0];
    assign in_cp    = s_tdata[30:10];
    assign in_bx    = s_tdata[46:31];
    assign in_by    = s_tdata[62:47];
    assign in_w     = s_tdata[78:63];
    assign in_h     = s_tdata[94:79];
    assign in_adv   = s_tdata[110:95];
    assign in_bms   = s_tdata[142:111];
    assign in_left  = s_tdata[152:143];
    assign in_right = s_tdata[162:153];
    assign in_kern  = s_tdata[178:163];

    // registers
    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          lo_reg, lo_next;
    logic [CW-1:0]          hi_reg, hi_next;      // exclusive upper bound
    logic [CW-1:0]          mid_reg, mid_next;
    logic [CP_W-1:0]        key_reg, key_next;
    logic                   kern_sel_reg, kern_sel_next;
    logic                   hit_reg, hit_next;
    logic [USED_W-1:0]      glyph_used_reg, glyph_used_next;
    logic [USED_W-1:0]      kern_used_reg, kern_used_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    logic                   s_accept;
    logic                   out_free;
    logic [CW-1:0]          glyph_cnt, kern_cnt;
    logic [CW-1:0]          mid_calc;
    logic [CP_W-1:0]        probe_key;
    logic                   key_eq, key_lt;

    // memory ports
    logic                   g_we, g_re;
    logic [GAW-1:0]         g_waddr, g_raddr;
    logic [GENT_W-1:0]      g_wdata, g_rdata;
    logic                   k_we, k_re;
    logic [KAW-1:0]         k_waddr, k_raddr;
    logic [KENT_W-1:0]      k_wdata, k_rdata;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // used counts saturate at the table depth
    assign glyph_cnt = (32'(glyph_used_reg) > 32'(GLYPH_DEPTH)) ? CW'(GLYPH_DEPTH)
                                                                : CW'(glyph_used_reg);
    assign kern_cnt  = (32'(kern_used_reg) > 32'(KERN_DEPTH)) ? CW'(KERN_DEPTH)
                                                              : CW'(kern_used_reg);

    // midpoint of [lo, hi): lo + (hi - 1 - lo) / 2, only used when lo < hi
    assign mid_calc = lo_reg + ((hi_reg - CW'(1) - lo_reg) >> 1);

    // entry writes go straight to the memories on acceptance
    assign g_we    = s_accept && (in_op == OP_WRITE_GLYPH) && (32'(in_slot) < 32'(GLYPH_DEPTH));
    assign g_waddr = GAW'(in_slot);
    assign g_wdata = {in_bms, in_adv, in_h, in_w, in_by, in_bx, in_cp};
    assign k_we    = s_accept && (in_op == OP_WRITE_KERN) && (32'(in_slot) < 32'(KERN_DEPTH));
    assign k_waddr = KAW'(in_slot);
    assign k_wdata = {in_kern, in_left, in_right};

    // one midpoint read per bisection step; read data holds until the next read
    assign g_re    = (state_reg == S_ISSUE) && !kern_sel_reg && (lo_reg < hi_reg);
    assign k_re    = (state_reg == S_ISSUE) &&  kern_sel_reg && (lo_reg < hi_reg);
    assign g_raddr = mid_calc[GAW-1:0];
    assign k_raddr = mid_calc[KAW-1:0];

    // shared key compare
    assign probe_key = kern_sel_reg ? CP_W'(k_rdata[KKEY_W-1:0]) : g_rdata[CP_W-1:0];
    assign key_eq    = (probe_key == key_reg);
    assign key_lt    = (probe_key < key_reg);

    gks_ram #(
        .WIDTH (GENT_W),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gks_ram #(
        .WIDTH (KENT_W),
        .DEPTH (KERN_DEPTH)
    ) u_kern_ram (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .re    (k_re),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        key_next        = key_reg;
        kern_sel_next   = kern_sel_reg;
        hit_next        = hit_reg;
        glyph_used_next = glyph_used_reg;
        kern_used_next  = kern_used_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        // register writes; indexes beyond the list are dropped
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_GLYPH_USED) begin
                glyph_used_next = cfg_data;
            end else if (cfg_index == REG_KERN_USED) begin
                kern_used_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (in_op == OP_FIND_GLYPH) begin
                        key_next      = in_cp;
                        kern_sel_next = 1'b0;
                        lo_next       = '0;
                        hi_next       = glyph_cnt;
                        state_next    = S_ISSUE;
                    end else if (in_op == OP_FIND_KERN) begin
                        key_next      = CP_W'({in_left, in_right});
                        kern_sel_next = 1'b1;
                        lo_next       = '0;
                        hi_next       = kern_cnt;
                        state_next    = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_calc;
                    state_next = S_CMP;
                end else begin
                    // range exhausted or table empty
                    hit_next   = 1'b0;
                    state_next = S_DONE;
                end
            end
            S_CMP: begin
                if (key_eq) begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end else if (key_lt) begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = S_ISSUE;
                end else begin
                    hi_next    = mid_reg;
                    state_next = S_ISSUE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_reg;
                    m_tdata_next  = '0;
                    if (hit_reg && kern_sel_reg) begin
                        m_tdata_next[137:122] = k_rdata[KENT_W-1:KKEY_W];
                    end else if (hit_reg) begin
                        m_tdata_next = {{PAD_W{1'b0}}, {M16_W{1'b0}},
                                        g_rdata[GENT_W-1:CP_W], POS_W'(mid_reg)};
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            glyph_used_reg <= '0;
            kern_used_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            glyph_used_reg <= glyph_used_next;
            kern_used_reg  <= kern_used_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        kern_sel_reg <= kern_sel_next;
        hit_reg      <= hit_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a compare only ever sees a non-empty range with the probe inside it
    `GKS_ASSERT_SAME(a_cmp_range, state_reg == S_CMP, lo_reg < hi_reg)
    `GKS_ASSERT_SAME(a_cmp_mid, state_reg == S_CMP, (mid_reg >= lo_reg) && (mid_reg < hi_reg))
    // a new result only appears as the sequencer leaves its done state
    `GKS_ASSERT_SAME(a_result_src, m_tvalid_reg && !$past(m_tvalid_reg),
                     $past(state_reg) == S_DONE)
    // entry writes never start a search
    `GKS_ASSERT_NEXT(a_write_idle, s_accept && ((in_op == OP_WRITE_GLYPH) ||
                     (in_op == OP_WRITE_KERN)), state_reg == S_IDLE)

endmodule

>>> rtl/gks_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module gks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
